// File: hw/rtl/gcb_pkg.sv
// Shared types and codes of the GC budget coordinator: item and result words,
// action and status codes, datapath operation codes and the controller link.
// No dependencies.
`default_nettype none

package gcb_pkg;

	// Input word
	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] ns_id;
		logic [31:0] free_blk;
		logic [31:0] total_blk;
		logic [39:0] invalid_pg;
		logic [39:0] valid_pg;
		logic [31:0] host_pg;
		logic [31:0] flash_pg;
	} in_t;

	// Result word
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot_index;
		logic [31:0] budget;
		logic [31:0] amplification;
		logic        last;
	} out_t;

	// One slot table entry
	typedef struct packed {
		logic [31:0] nsid;
		logic [16:0] score;
		logic [63:0] host;
		logic [63:0] flash;
		logic [31:0] share;
	} rec_t;

	// Actions
	localparam logic [2:0] ACT_REG   = 3'd0;
	localparam logic [2:0] ACT_UNREG = 3'd1;
	localparam logic [2:0] ACT_UPD   = 3'd2;
	localparam logic [2:0] ACT_ALLOC = 3'd3;
	localparam logic [2:0] ACT_REC   = 3'd4;
	localparam logic [2:0] ACT_WAF   = 3'd5;

	// Result status
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_EXISTS   = 3'd2;
	localparam logic [2:0] ST_NOFREE   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_TOTAL = 2'd0;
	localparam logic [1:0] CFG_THR   = 2'd1;
	localparam logic [1:0] CFG_MIN   = 2'd2;

	localparam logic [31:0] TOTAL_RST = 32'd1024;
	localparam logic [16:0] THR_RST   = 17'd32768;
	localparam logic [31:0] MIN_RST   = 32'd0;
	localparam logic [31:0] WAF_ONE   = 32'd65536;
	localparam logic [16:0] SCORE_MAX = 17'd65536;
	localparam int          SCORE_W   = 17;

	// Shared divider geometry
	localparam int DIV_NW    = 80;
	localparam int DIV_DW    = 64;
	localparam int DIV_CW    = 7;
	localparam int DIV_STEPS = 80;

	// Datapath operations
	localparam logic [4:0] OP_NOP      = 5'd0;
	localparam logic [4:0] OP_LOAD     = 5'd1;
	localparam logic [4:0] OP_READ     = 5'd2;
	localparam logic [4:0] OP_SCAN     = 5'd3;
	localparam logic [4:0] OP_EMIT_ST  = 5'd4;
	localparam logic [4:0] OP_REG_WR   = 5'd5;
	localparam logic [4:0] OP_UNREG    = 5'd6;
	localparam logic [4:0] OP_T1_GO    = 5'd7;
	localparam logic [4:0] OP_T2_GO    = 5'd8;
	localparam logic [4:0] OP_UPD_WR   = 5'd9;
	localparam logic [4:0] OP_REC_WR   = 5'd10;
	localparam logic [4:0] OP_WAF_GO   = 5'd11;
	localparam logic [4:0] OP_WAF_EMIT = 5'd12;
	localparam logic [4:0] OP_ACC      = 5'd13;
	localparam logic [4:0] OP_MIN      = 5'd14;
	localparam logic [4:0] OP_SPLIT_GO = 5'd15;
	localparam logic [4:0] OP_NEXT     = 5'd16;
	localparam logic [4:0] OP_EVEN_WR  = 5'd17;
	localparam logic [4:0] OP_MUL      = 5'd18;
	localparam logic [4:0] OP_SHARE_GO = 5'd19;
	localparam logic [4:0] OP_SHARE_WR = 5'd20;
	localparam logic [4:0] OP_EMIT_AL  = 5'd21;

	// Controller to datapath
	typedef struct packed {
		logic [4:0] op;
		logic [2:0] status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [2:0] act;
		logic       id_zero;
		logic       tot_zero;
		logic       hit;
		logic       found;
		logic       free_ok;
		logic       idx_last;
		logic       div_busy;
		logic       host_zero;
		logic       over;
		logic       qual;
		logic       ssum_zero;
	} stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/gcb_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on gcb_pkg for its widths.
`default_nettype none

module gcb_div import gcb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [DIV_NW-1:0] num,
	input  wire logic [DIV_DW-1:0] den,
	output logic                   busy,
	output logic [DIV_NW-1:0]      quo,
	output logic [DIV_DW-1:0]      rem
);

	logic              busy_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	// Trial subtract of the shifted remainder
	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CW'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift dividend out, quotient in
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], ge};
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/gcb_datapath.sv
// Datapath: configuration, slot table memory, valid bits, scoring, allocation
// and write amplification arithmetic, and the result register.
// Depends on gcb_pkg and gcb_div.
`default_nettype none

module gcb_datapath import gcb_pkg::*; #(
	parameter int NS_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_t         item,
	input  wire logic        cfg_valid,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire cmd_t        cmd,
	output stat_t            stat,
	output out_t             result,
	output logic             result_strobe
);

	localparam int IW  = (NS_SLOTS > 1) ? $clog2(NS_SLOTS) : 1;
	localparam int CW  = $clog2(NS_SLOTS + 1);
	localparam int SSW = SCORE_W + CW;
	localparam logic [IW-1:0] LAST_IDX = IW'(NS_SLOTS - 1);

	// Configuration
	logic [31:0] total_q;
	logic [16:0] thr_q;
	logic [31:0] minb_q;

	// Item and table
	in_t                item_q;
	logic [NS_SLOTS-1:0] used_q;
	rec_t               mem [NS_SLOTS];
	rec_t               rd_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      fidx_q;
	logic [IW-1:0]      freeidx_q;
	logic               found_q;
	logic               free_ok_q;
	logic [16:0]        t1_q;

	// Allocation accumulators
	logic [CW-1:0]  cnt_q;
	logic [SSW-1:0] ssum_q;
	logic [IW-1:0]  best_q;
	logic [16:0]    bestsc_q;
	logic           over_q;
	logic [31:0]    rest_q;
	logic [31:0]    dist_q;
	logic [CW-1:0]  n_q;
	logic [48:0]    prod_q;

	out_t res_q;
	logic strobe_q;

	// Divider link
	logic              div_go;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic              div_busy;
	logic [DIV_NW-1:0] div_quo;
	logic [DIV_DW-1:0] div_rem;

	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	rec_t                wr_data;
	logic                emit;
	out_t                emit_res;

	logic                idx_last;
	logic [IW-1:0]       idx_nxt;
	logic                used_cur;
	logic                hit;
	logic                qual;
	logic [CW+31:0]      mtot;
	logic                over_c;
	logic [31:0]         diff_blk;
	logic [40:0]         pg_sum;
	logic [16:0]         t2;
	logic [17:0]         pos_sum;
	logic [16:0]         score_new;
	logic [64:0]         hsum;
	logic [64:0]         fsum;
	logic [CW-1:0]       lo;
	logic [31:0]         even_bud;
	logic [31:0]         ex;
	logic [31:0]         alloc_bud;
	logic [31:0]         amp;

	gcb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// Slot walk and qualification
	assign idx_last = idx_q == LAST_IDX;
	assign idx_nxt  = idx_last ? '0 : IW'(idx_q + 1'b1);
	assign used_cur = used_q[idx_q];
	assign hit      = used_cur && (rd_q.nsid == item_q.ns_id);
	assign qual     = used_cur && (rd_q.score >= thr_q);
	assign mtot     = (CW + 32)'(cnt_q) * (CW + 32)'(minb_q);
	assign over_c   = mtot > (CW + 32)'(total_q);

	// Score terms
	assign diff_blk = (item_q.free_blk <= item_q.total_blk) ?
		item_q.total_blk - item_q.free_blk : item_q.free_blk - item_q.total_blk;
	assign pg_sum   = {1'b0, item_q.invalid_pg} + {1'b0, item_q.valid_pg};
	assign t2       = (pg_sum == '0) ? '0 : div_quo[16:0];
	assign pos_sum  = {1'b0, t1_q} + {1'b0, t2};

	always_comb begin
		if (item_q.total_blk == '0) begin
			score_new = '0;
		end else if (item_q.free_blk > item_q.total_blk) begin
			score_new = (t1_q > t2) ? '0 : t2 - t1_q;
		end else if (pos_sum > {1'b0, SCORE_MAX}) begin
			score_new = SCORE_MAX;
		end else begin
			score_new = pos_sum[16:0];
		end
	end

	// Saturating write sums
	assign hsum = {1'b0, rd_q.host} + 65'(item_q.host_pg);
	assign fsum = {1'b0, rd_q.flash} + 65'(item_q.flash_pg);

	// Budget shares
	assign lo        = CW'(div_rem);
	assign even_bud  = div_quo[31:0] + 32'(n_q < lo);
	assign ex        = (ssum_q == '0) ? '0 : div_quo[31:0];
	assign alloc_bud = !qual ? '0 : rd_q.share +
		(((idx_q == best_q) && !over_q) ? rest_q - dist_q : 32'd0);
	assign amp       = (rd_q.host == '0) ? WAF_ONE :
		((div_quo[DIV_NW-1:32] != '0) ? '1 : div_quo[31:0]);

	// Divider operand select
	always_comb begin
		div_go  = 1'b0;
		div_num = '0;
		div_den = '0;
		case (cmd.op)
			OP_T1_GO: begin
				div_go  = 1'b1;
				div_num = (DIV_NW'(diff_blk) << 17) + (DIV_NW'(diff_blk) << 16);
				div_den = (DIV_DW'(item_q.total_blk) << 2) + DIV_DW'(item_q.total_blk);
			end
			OP_T2_GO: begin
				div_go  = 1'b1;
				div_num = DIV_NW'(item_q.invalid_pg) << 17;
				div_den = (DIV_DW'(pg_sum) << 2) + DIV_DW'(pg_sum);
			end
			OP_WAF_GO: begin
				div_go  = 1'b1;
				div_num = DIV_NW'(rd_q.flash) << 16;
				div_den = rd_q.host;
			end
			OP_SPLIT_GO: begin
				div_go  = 1'b1;
				div_num = DIV_NW'(total_q);
				div_den = DIV_DW'(cnt_q);
			end
			OP_SHARE_GO: begin
				div_go  = 1'b1;
				div_num = DIV_NW'(prod_q);
				div_den = DIV_DW'(ssum_q);
			end
			default: begin
			end
		endcase
	end

	// Table write and result select
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = rd_q;
		emit     = 1'b0;
		emit_res = '{status: ST_OK, slot_index: 4'(fidx_q), budget: '0,
			amplification: '0, last: 1'b1};
		case (cmd.op)
			OP_EMIT_ST: begin
				emit                   = 1'b1;
				emit_res.status        = cmd.status;
				emit_res.slot_index    = '0;
				emit_res.amplification = (item_q.action == ACT_WAF) ? WAF_ONE : '0;
			end
			OP_REG_WR: begin
				wr_en               = 1'b1;
				wr_addr             = freeidx_q;
				wr_data             = '0;
				wr_data.nsid        = item_q.ns_id;
				emit                = 1'b1;
				emit_res.slot_index = 4'(freeidx_q);
			end
			OP_UNREG: begin
				emit = 1'b1;
			end
			OP_UPD_WR: begin
				wr_en         = 1'b1;
				wr_addr       = fidx_q;
				wr_data.score = score_new;
				emit          = 1'b1;
			end
			OP_REC_WR: begin
				wr_en         = 1'b1;
				wr_addr       = fidx_q;
				wr_data.host  = hsum[64] ? '1 : hsum[63:0];
				wr_data.flash = fsum[64] ? '1 : fsum[63:0];
				emit          = 1'b1;
			end
			OP_WAF_EMIT: begin
				emit                   = 1'b1;
				emit_res.amplification = amp;
			end
			OP_EVEN_WR: begin
				wr_en         = 1'b1;
				wr_data.share = even_bud;
			end
			OP_SHARE_WR: begin
				wr_en         = 1'b1;
				wr_data.share = minb_q + ex;
			end
			OP_EMIT_AL: begin
				emit                = 1'b1;
				emit_res.slot_index = 4'(idx_q);
				emit_res.budget     = alloc_bud;
				emit_res.last       = idx_last;
			end
			default: begin
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RST;
			thr_q   <= THR_RST;
			minb_q  <= MIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TOTAL: total_q <= cfg_data;
				CFG_THR:   thr_q   <= cfg_data[16:0];
				CFG_MIN:   minb_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Control state: valid bits, walk index, flags, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			cnt_q     <= '0;
			n_q       <= '0;
			over_q    <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= emit;
			case (cmd.op)
				OP_LOAD: begin
					idx_q     <= '0;
					found_q   <= 1'b0;
					free_ok_q <= 1'b0;
					cnt_q     <= '0;
				end
				OP_SCAN: begin
					idx_q <= idx_nxt;
					if (hit) begin
						found_q <= 1'b1;
					end
					if (!used_cur) begin
						free_ok_q <= 1'b1;
					end
				end
				OP_REG_WR: used_q[freeidx_q] <= 1'b1;
				OP_UNREG:  used_q[fidx_q]    <= 1'b0;
				OP_ACC: begin
					idx_q <= idx_nxt;
					if (qual) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				OP_MIN: begin
					over_q <= over_c;
					n_q    <= '0;
				end
				OP_NEXT, OP_SHARE_WR, OP_EMIT_AL: idx_q <= idx_nxt;
				OP_EVEN_WR: begin
					idx_q <= idx_nxt;
					n_q   <= n_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_res;
		end
		case (cmd.op)
			OP_LOAD: begin
				item_q <= item;
				ssum_q <= '0;
			end
			OP_SCAN: begin
				if (hit) begin
					fidx_q <= idx_q;
				end
				if (!used_cur && !free_ok_q) begin
					freeidx_q <= idx_q;
				end
			end
			OP_T2_GO: t1_q <= (div_quo[DIV_NW-1:17] != '0) ? '1 : div_quo[16:0];
			OP_ACC: begin
				if (qual) begin
					ssum_q <= ssum_q + SSW'(rd_q.score);
					if (cnt_q == '0 || rd_q.score > bestsc_q) begin
						best_q   <= idx_q;
						bestsc_q <= rd_q.score;
					end
				end
			end
			OP_MIN: begin
				rest_q <= total_q - mtot[31:0];
				dist_q <= '0;
			end
			OP_MUL: prod_q <= 49'(rd_q.score) * 49'(rest_q);
			OP_SHARE_WR: dist_q <= dist_q + ex;
			default: begin
			end
		endcase
	end

	// Slot table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.op == OP_READ) begin
			rd_q <= mem[idx_q];
		end
	end

	assign stat = '{
		act:       item_q.action,
		id_zero:   item_q.ns_id == '0,
		tot_zero:  item_q.total_blk == '0,
		hit:       hit,
		found:     found_q,
		free_ok:   free_ok_q,
		idx_last:  idx_last,
		div_busy:  div_busy,
		host_zero: rd_q.host == '0,
		over:      over_q,
		qual:      qual,
		ssum_zero: ssum_q == '0
	};

	assign result        = res_q;
	assign result_strobe = strobe_q;

endmodule

`default_nettype wire

// File: hw/rtl/gcb_ctrl.sv
// Controller state machine: sequences table scans, divisions and the three
// allocation passes by issuing datapath operations.
// Depends on gcb_pkg.
`default_nettype none

module gcb_ctrl import gcb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire stat_t stat,
	output logic       busy,
	output cmd_t       cmd
);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DEC      = 5'd1;
	localparam logic [4:0] S_SC_RD    = 5'd2;
	localparam logic [4:0] S_SC_CMP   = 5'd3;
	localparam logic [4:0] S_ACT      = 5'd4;
	localparam logic [4:0] S_T1_WAIT  = 5'd5;
	localparam logic [4:0] S_T2_WAIT  = 5'd6;
	localparam logic [4:0] S_WAF_WAIT = 5'd7;
	localparam logic [4:0] S_AL_RD    = 5'd8;
	localparam logic [4:0] S_AL_ACC   = 5'd9;
	localparam logic [4:0] S_AL_MIN   = 5'd10;
	localparam logic [4:0] S_AL_BR    = 5'd11;
	localparam logic [4:0] S_SPL_WAIT = 5'd12;
	localparam logic [4:0] S_P2_RD    = 5'd13;
	localparam logic [4:0] S_P2_CHK   = 5'd14;
	localparam logic [4:0] S_P2_MUL   = 5'd15;
	localparam logic [4:0] S_P2_WAIT  = 5'd16;
	localparam logic [4:0] S_P3_RD    = 5'd17;
	localparam logic [4:0] S_P3_OUT   = 5'd18;

	logic [4:0] state_q;
	logic [4:0] state_nxt;

	// Next state and operation
	always_comb begin
		state_nxt  = state_q;
		cmd.op     = OP_NOP;
		cmd.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op    = OP_LOAD;
					state_nxt = S_DEC;
				end
			end
			S_DEC: begin
				if (stat.act == ACT_ALLOC) begin
					state_nxt = S_AL_RD;
				end else if (stat.act > ACT_WAF || stat.id_zero ||
						(stat.act == ACT_REG && stat.tot_zero)) begin
					cmd.op     = OP_EMIT_ST;
					cmd.status = ST_INVALID;
					state_nxt  = S_IDLE;
				end else begin
					state_nxt = S_SC_RD;
				end
			end
			S_SC_RD: begin
				cmd.op    = OP_READ;
				state_nxt = S_SC_CMP;
			end
			S_SC_CMP: begin
				cmd.op    = OP_SCAN;
				state_nxt = (stat.hit || stat.idx_last) ? S_ACT : S_SC_RD;
			end
			S_ACT: begin
				state_nxt = S_IDLE;
				if (stat.act == ACT_REG) begin
					if (stat.found) begin
						cmd.op     = OP_EMIT_ST;
						cmd.status = ST_EXISTS;
					end else if (!stat.free_ok) begin
						cmd.op     = OP_EMIT_ST;
						cmd.status = ST_NOFREE;
					end else begin
						cmd.op = OP_REG_WR;
					end
				end else if (!stat.found) begin
					cmd.op     = OP_EMIT_ST;
					cmd.status = ST_NOTFOUND;
				end else begin
					case (stat.act)
						ACT_UNREG: cmd.op = OP_UNREG;
						ACT_UPD: begin
							if (stat.tot_zero) begin
								cmd.op = OP_UPD_WR;
							end else begin
								cmd.op    = OP_T1_GO;
								state_nxt = S_T1_WAIT;
							end
						end
						ACT_REC: cmd.op = OP_REC_WR;
						default: begin
							if (stat.host_zero) begin
								cmd.op = OP_WAF_EMIT;
							end else begin
								cmd.op    = OP_WAF_GO;
								state_nxt = S_WAF_WAIT;
							end
						end
					endcase
				end
			end
			S_T1_WAIT: begin
				if (!stat.div_busy) begin
					cmd.op    = OP_T2_GO;
					state_nxt = S_T2_WAIT;
				end
			end
			S_T2_WAIT: begin
				if (!stat.div_busy) begin
					cmd.op    = OP_UPD_WR;
					state_nxt = S_IDLE;
				end
			end
			S_WAF_WAIT: begin
				if (!stat.div_busy) begin
					cmd.op    = OP_WAF_EMIT;
					state_nxt = S_IDLE;
				end
			end
			// Pass one: count, score sum, best slot
			S_AL_RD: begin
				cmd.op    = OP_READ;
				state_nxt = S_AL_ACC;
			end
			S_AL_ACC: begin
				cmd.op    = OP_ACC;
				state_nxt = stat.idx_last ? S_AL_MIN : S_AL_RD;
			end
			S_AL_MIN: begin
				cmd.op    = OP_MIN;
				state_nxt = S_AL_BR;
			end
			S_AL_BR: begin
				if (stat.over) begin
					cmd.op    = OP_SPLIT_GO;
					state_nxt = S_SPL_WAIT;
				end else begin
					state_nxt = S_P2_RD;
				end
			end
			S_SPL_WAIT: begin
				if (!stat.div_busy) begin
					state_nxt = S_P2_RD;
				end
			end
			// Pass two: per-slot shares into the table
			S_P2_RD: begin
				cmd.op    = OP_READ;
				state_nxt = S_P2_CHK;
			end
			S_P2_CHK: begin
				state_nxt = stat.idx_last ? S_P3_RD : S_P2_RD;
				if (!stat.qual) begin
					cmd.op = OP_NEXT;
				end else if (stat.over) begin
					cmd.op = OP_EVEN_WR;
				end else if (stat.ssum_zero) begin
					cmd.op = OP_SHARE_WR;
				end else begin
					cmd.op    = OP_MUL;
					state_nxt = S_P2_MUL;
				end
			end
			S_P2_MUL: begin
				cmd.op    = OP_SHARE_GO;
				state_nxt = S_P2_WAIT;
			end
			S_P2_WAIT: begin
				if (!stat.div_busy) begin
					cmd.op    = OP_SHARE_WR;
					state_nxt = stat.idx_last ? S_P3_RD : S_P2_RD;
				end
			end
			// Pass three: emit one word per slot
			S_P3_RD: begin
				cmd.op    = OP_READ;
				state_nxt = S_P3_OUT;
			end
			S_P3_OUT: begin
				cmd.op    = OP_EMIT_AL;
				state_nxt = stat.idx_last ? S_IDLE : S_P3_RD;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

`default_nettype wire

// File: hw/rtl/gc_budget_coordinator.sv
// Timing: register/unregister/record scan k slots (k <= NS_SLOTS);
// update adds two 80-step divisions, WAF query one. Allocate walks the table three
// times and divides once per qualifying slot (none when their scores sum to zero),
// or only once in all when the minimums overrun the total.
// Throughput: one item at a time, results cannot be stalled; the next start is taken at
// the edge that ends the last result word, and all items share one bit-serial divider.
`default_nettype none

module gc_budget_coordinator import gcb_pkg::*; #(
	parameter int NS_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_t         item,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             result_strobe,
	output out_t             result
);

	// Reset: arst_n clears slot valid bits and loads configuration reset values.

	cmd_t  cmd;
	stat_t stat;

	gcb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	gcb_datapath #(.NS_SLOTS(NS_SLOTS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.stat          (stat),
		.result        (result),
		.result_strobe (result_strobe)
	);

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |-> !busy)
		else $error("final result word while still busy");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |-> busy)
		else $error("non-final result word with controller idle");

	a_budget_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.budget != '0 |->
			result.status == ST_OK && result.amplification == '0)
		else $error("budget on a non-allocation result");
`endif

endmodule

`default_nettype wire
